FILE: rtl/core/pptt_pkg.sv
// Shared types and constants for the PPS pulse and trigger timer.
package pptt_pkg;

    // Input commands
    typedef enum logic [2:0] {
        CMD_TICK          = 3'd0,
        CMD_DIVISOR_NEXT  = 3'd1,
        CMD_DIVISOR_ONCE  = 3'd2,
        CMD_DELAY_NEXT    = 3'd3,
        CMD_SECONDS_NOW   = 3'd4,
        CMD_SECONDS_NEXT  = 3'd5,
        CMD_TICKS_NOW     = 3'd6
    } cmd_t;

    localparam logic [63:0] INIT_DIVISOR = 64'd203999999;
    localparam logic [31:0] INIT_WIDTH   = 32'd4000;
    localparam logic [63:0] INIT_DELAY   = 64'd40000000;

    typedef struct packed {
        logic [2:0]         command;
        logic signed [63:0] value;
    } in_t;

    typedef struct packed {
        logic               pps_level;
        logic               trigger_level;
        logic               second_start;
        logic signed [63:0] seconds;
        logic [31:0]        ticks;
    } out_t;

endpackage

FILE: rtl/core/pptt_timer_core.sv
// Timer state and single-pass update logic for one item.
module pptt_timer_core #(
    parameter int COUNT_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           item_en,
    input  pptt_pkg::in_t  item,
    output pptt_pkg::out_t result
);
    import pptt_pkg::*;

    logic [31:0]            pulse_width_reg;
    logic [COUNT_BITS-1:0]  tick_reg, tick_next;
    logic                   pulse_reg, pulse_next;
    logic [COUNT_BITS-1:0]  period_reg, period_next;
    logic [COUNT_BITS-1:0]  trig_match_reg, trig_match_next;
    logic [COUNT_BITS-1:0]  act_div_reg, act_div_next;
    logic [COUNT_BITS-1:0]  q_div_reg, q_div_next;
    logic [COUNT_BITS-1:0]  once_div_reg, once_div_next;
    logic [COUNT_BITS-1:0]  act_delay_reg, act_delay_next;
    logic [COUNT_BITS-1:0]  q_delay_reg, q_delay_next;
    logic signed [63:0]     sec_reg, sec_next;
    logic signed [63:0]     q_sec_reg, q_sec_next;
    logic                   pps_reg, pps_next;
    logic                   trig_reg, trig_next;

    logic [COUNT_BITS-1:0]  cval;
    logic [COUNT_BITS-1:0]  pw_c;
    logic [COUNT_BITS-1:0]  tick_inc;
    logic                   started;

    assign cval     = item.value[COUNT_BITS-1:0];
    assign pw_c     = COUNT_BITS'(pulse_width_reg);
    assign tick_inc = tick_reg + {{(COUNT_BITS-1){1'b0}}, 1'b1};

    always_comb begin
        logic [COUNT_BITS-1:0] div_sel;
        logic [COUNT_BITS-1:0] delay_sel;
        div_sel         = (q_div_reg != '0) ? q_div_reg : act_div_reg;
        delay_sel       = (q_delay_reg != '0) ? q_delay_reg : act_delay_reg;
        tick_next       = tick_reg;
        pulse_next      = pulse_reg;
        period_next     = period_reg;
        trig_match_next = trig_match_reg;
        act_div_next    = act_div_reg;
        q_div_next      = q_div_reg;
        once_div_next   = once_div_reg;
        act_delay_next  = act_delay_reg;
        q_delay_next    = q_delay_reg;
        sec_next        = sec_reg;
        q_sec_next      = q_sec_reg;
        pps_next        = pps_reg;
        trig_next       = trig_reg;
        started         = 1'b0;
        unique case (cmd_t'(item.command))
            CMD_TICK: begin
                if (!pulse_reg && tick_reg == period_reg) begin
                    // second start
                    started    = 1'b1;
                    tick_next  = '0;
                    pulse_next = 1'b1;
                    pps_next   = 1'b1;
                    if (q_sec_reg != 64'sd0) begin
                        sec_next   = q_sec_reg;
                        q_sec_next = 64'sd0;
                    end else begin
                        sec_next = sec_reg + 64'sd1;
                    end
                end else begin
                    tick_next = tick_inc;
                    if (pulse_reg) begin
                        if (tick_inc == pw_c) begin
                            // pulse end: pending values take effect
                            pps_next        = 1'b0;
                            trig_next       = 1'b0;
                            pulse_next      = 1'b0;
                            act_div_next    = div_sel;
                            q_div_next      = '0;
                            period_next     = (once_div_reg != '0) ? once_div_reg : div_sel;
                            once_div_next   = '0;
                            act_delay_next  = delay_sel;
                            q_delay_next    = '0;
                            trig_match_next = delay_sel;
                        end
                    end else if (tick_inc == trig_match_reg) begin
                        trig_next = 1'b1;
                    end
                end
            end
            CMD_DIVISOR_NEXT: q_div_next    = cval;
            CMD_DIVISOR_ONCE: once_div_next = cval;
            CMD_DELAY_NEXT:   q_delay_next  = cval;
            CMD_SECONDS_NOW:  sec_next      = item.value;
            CMD_SECONDS_NEXT: q_sec_next    = item.value;
            CMD_TICKS_NOW:    tick_next     = cval;
            default: ;
        endcase
    end

    always_comb begin
        result.pps_level     = pps_next;
        result.trigger_level = trig_next;
        result.second_start  = started;
        result.seconds       = sec_next;
        result.ticks         = 32'(tick_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_width_reg <= INIT_WIDTH;
        end else if (cfg_we) begin
            pulse_width_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg       <= '0;
            pulse_reg      <= 1'b0;
            period_reg     <= COUNT_BITS'(INIT_DIVISOR);
            trig_match_reg <= COUNT_BITS'(INIT_DELAY);
            act_div_reg    <= COUNT_BITS'(INIT_DIVISOR);
            q_div_reg      <= '0;
            once_div_reg   <= '0;
            act_delay_reg  <= COUNT_BITS'(INIT_DELAY);
            q_delay_reg    <= '0;
            sec_reg        <= 64'sd0;
            q_sec_reg      <= 64'sd0;
            pps_reg        <= 1'b0;
            trig_reg       <= 1'b0;
        end else if (item_en) begin
            tick_reg       <= tick_next;
            pulse_reg      <= pulse_next;
            period_reg     <= period_next;
            trig_match_reg <= trig_match_next;
            act_div_reg    <= act_div_next;
            q_div_reg      <= q_div_next;
            once_div_reg   <= once_div_next;
            act_delay_reg  <= act_delay_next;
            q_delay_reg    <= q_delay_next;
            sec_reg        <= sec_next;
            q_sec_reg      <= q_sec_next;
            pps_reg        <= pps_next;
            trig_reg       <= trig_next;
        end
    end

    // PPS is high only inside the pulse phase
    a_pps_in_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        !pulse_reg |-> !pps_reg)
        else $error("pps high outside pulse phase");

    // a second start leaves the counter at zero in the pulse phase
    a_start_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_en && started) |=> (tick_reg == '0 && pulse_reg && pps_reg))
        else $error("second start did not restart the count");

endmodule

FILE: rtl/core/pps_pulse_and_trigger_timer_top.sv
// Top level of the PPS pulse and trigger timer: input and result registers around the core.
//
// PPS pulse and trigger timer. Each transfer on the s_ channel is one command:
// a tick advances the period counter by one, or clears it at a second start;
// the others set or queue the divisor, one-shot divisor, trigger delay, seconds
// or tick count (a queued value of zero cancels the request). Every input
// transfer yields exactly one result transfer on the m_ channel with the PPS and
// trigger levels, a second-start flag, the seconds count and the tick count after
// that command. Throughput is one item per clock while m_ready keeps up: the
// input register feeds a single-pass update of the timer state that loads the
// result register. While a finished result waits for m_ready the input register
// takes one more transfer, then s_ready stays low until the result moves.
// pulse_width is to be written through cfg_we/cfg_wdata only while no items are
// in flight, which the block does not enforce; it resets to 4000. COUNT_BITS
// sets the width of the tick counter and of the divisors and delay.
module pps_pulse_and_trigger_timer_top #(
    parameter int COUNT_BITS = 32
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           cfg_we,
    input  logic [31:0]    cfg_wdata,
    input  logic           s_valid,
    output logic           s_ready,
    input  pptt_pkg::in_t  s_data,
    output logic           m_valid,
    input  logic           m_ready,
    output pptt_pkg::out_t m_data
);
    import pptt_pkg::*;

    logic  in_vld_reg;
    in_t   in_data_reg;
    logic  m_vld_reg;
    out_t  m_data_reg;
    out_t  core_result;
    logic  advance;

    // the item in the input register moves on when the result slot is free
    // or is being emptied this cycle
    assign advance = in_vld_reg && (!m_vld_reg || m_ready);
    assign s_ready = !in_vld_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
        end else if (s_ready) begin
            in_vld_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    pptt_timer_core #(
        .COUNT_BITS (COUNT_BITS)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .item_en   (advance),
        .item      (in_data_reg),
        .result    (core_result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_vld_reg <= 1'b0;
        end else if (advance) begin
            m_vld_reg <= 1'b1;
        end else if (m_ready) begin
            m_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= core_result;
        end
    end

    assign m_valid = m_vld_reg;
    assign m_data  = m_data_reg;

    // a second start always reports PPS high and a zero count
    a_start_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.second_start) |-> (m_data.pps_level && m_data.ticks == 32'd0))
        else $error("second start result inconsistent");

    // input side only stalls while an item is held
    a_stall_held: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_vld_reg && m_vld_reg && !m_ready))
        else $error("input stalled without a held item");

endmodule

FILE: tb/pps_timer_checker.sv
// Timer checker: tracks the timer state from accepted commands and compares each result.
module pps_timer_checker (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [31:0]      cfg_wdata,
    input  logic             s_valid,
    input  logic             s_ready,
    input  pptt_pkg::in_t    s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  pptt_pkg::out_t   m_data,
    output int               pending,
    output int               fail_count,
    output int               starts_seen
);
    import pptt_pkg::*;

    // predicted timer state, 32-bit counter
    logic [31:0] width_ticks;
    logic [31:0] tick_cnt;
    logic        pulsing;
    logic [31:0] period_end;
    logic [31:0] trigger_at;
    logic [31:0] divisor_now;
    logic [31:0] divisor_queued;
    logic [31:0] divisor_once;
    logic [31:0] delay_now;
    logic [31:0] delay_queued;
    logic [63:0] secs;
    logic [63:0] secs_queued;
    logic        pps_q;
    logic        trig_q;

    out_t timer_results_due[$];

    task automatic clear_timer();
        width_ticks    = INIT_WIDTH;
        tick_cnt       = '0;
        pulsing        = 1'b0;
        period_end     = INIT_DIVISOR[31:0];
        trigger_at     = INIT_DELAY[31:0];
        divisor_now    = INIT_DIVISOR[31:0];
        divisor_queued = '0;
        divisor_once   = '0;
        delay_now      = INIT_DELAY[31:0];
        delay_queued   = '0;
        secs           = '0;
        secs_queued    = '0;
        pps_q          = 1'b0;
        trig_q         = 1'b0;
    endtask

    task automatic step_timer(input in_t item, output out_t res);
        logic started;
        started = 1'b0;
        case (item.command)
            CMD_TICK: begin
                if (!pulsing && tick_cnt == period_end) begin
                    // second start
                    tick_cnt = '0;
                    pulsing  = 1'b1;
                    pps_q    = 1'b1;
                    secs     = secs + 64'd1;
                    if (secs_queued != '0) begin
                        secs        = secs_queued;
                        secs_queued = '0;
                    end
                    started = 1'b1;
                end else begin
                    tick_cnt = tick_cnt + 32'd1;
                    if (pulsing) begin
                        if (tick_cnt == width_ticks) begin
                            // pulse end: pending values take effect
                            pps_q   = 1'b0;
                            trig_q  = 1'b0;
                            pulsing = 1'b0;
                            if (divisor_queued != '0) begin
                                divisor_now    = divisor_queued;
                                divisor_queued = '0;
                            end
                            if (divisor_once != '0) begin
                                period_end   = divisor_once;
                                divisor_once = '0;
                            end else begin
                                period_end = divisor_now;
                            end
                            if (delay_queued != '0) begin
                                delay_now    = delay_queued;
                                delay_queued = '0;
                            end
                            trigger_at = delay_now;
                        end
                    end else if (tick_cnt == trigger_at) begin
                        trig_q = 1'b1;
                    end
                end
            end
            CMD_DIVISOR_NEXT: divisor_queued = item.value[31:0];
            CMD_DIVISOR_ONCE: divisor_once   = item.value[31:0];
            CMD_DELAY_NEXT:   delay_queued   = item.value[31:0];
            CMD_SECONDS_NOW:  secs           = item.value;
            CMD_SECONDS_NEXT: secs_queued    = item.value;
            CMD_TICKS_NOW:    tick_cnt       = item.value[31:0];
            default: ;
        endcase
        res.pps_level     = pps_q;
        res.trigger_level = trig_q;
        res.second_start  = started;
        res.seconds       = secs;
        res.ticks         = tick_cnt;
    endtask

    always @(posedge aclk) begin : monitor
        out_t exp_res;
        out_t got;
        if (!aresetn) begin
            clear_timer();
            timer_results_due.delete();
            fail_count  = 0;
            starts_seen = 0;
        end else begin
            if (cfg_we)
                width_ticks = cfg_wdata;
            if (m_valid && m_ready) begin
                got = m_data;
                if (timer_results_due.size() == 0) begin
                    $error("result transfer with nothing expected (ticks %0d)", got.ticks);
                    fail_count++;
                end else begin
                    exp_res = timer_results_due.pop_front();
                    if (got.pps_level !== exp_res.pps_level) begin
                        $error("pps_level: expected %0b, got %0b",
                               exp_res.pps_level, got.pps_level);
                        fail_count++;
                    end
                    if (got.trigger_level !== exp_res.trigger_level) begin
                        $error("trigger_level: expected %0b, got %0b",
                               exp_res.trigger_level, got.trigger_level);
                        fail_count++;
                    end
                    if (got.second_start !== exp_res.second_start) begin
                        $error("second_start: expected %0b, got %0b",
                               exp_res.second_start, got.second_start);
                        fail_count++;
                    end
                    if (got.seconds !== exp_res.seconds) begin
                        $error("seconds: expected %0d, got %0d",
                               exp_res.seconds, got.seconds);
                        fail_count++;
                    end
                    if (got.ticks !== exp_res.ticks) begin
                        $error("ticks: expected %0d, got %0d", exp_res.ticks, got.ticks);
                        fail_count++;
                    end
                    if (exp_res.second_start)
                        starts_seen++;
                end
            end
            if (s_valid && s_ready) begin
                step_timer(s_data, exp_res);
                timer_results_due.push_back(exp_res);
            end
        end
        pending = timer_results_due.size();
    end

endmodule

FILE: tb/testbench.sv
// Top of the timer testbench: clock, reset, command stimulus, result back-pressure, verdict.
module testbench;
    import pptt_pkg::*;

    // command code outside the defined set; the timer must ignore it
    localparam logic [2:0] CMD_UNUSED = 3'd7;

    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 150;
    // settle margin after draining, before a pulse width write
    localparam int SETTLE_CYCLES   = 4;
    localparam int END_CYCLES      = 10;
    localparam int CYCLE_LIMIT     = 400000;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    in_t         s_data;
    logic        m_valid;
    logic        m_ready;
    out_t        m_data;

    int pending;
    int fail_count;
    int starts_seen;

    // sender bookkeeping
    int burst_left;
    int sent_items;
    int tick_items;
    int width_writes;
    int drains;
    int cycles;

    pps_pulse_and_trigger_timer_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    pps_timer_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .pending     (pending),
        .fail_count  (fail_count),
        .starts_seen (starts_seen)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Result side back-pressure. A new ready mask is drawn each time the slot
    // counter wraps: always ready, coin flip, mostly stalled or mostly ready.
    initial begin : receiver
        logic [31:0] ready_mask;
        int          slot;
        m_ready    = 1'b0;
        ready_mask = '1;
        slot       = 0;
        forever begin
            @(negedge aclk);
            if (slot == 0) begin
                case ($urandom_range(0, 3))
                    0:       ready_mask = '1;
                    1:       ready_mask = $urandom;
                    2:       ready_mask = $urandom & $urandom;
                    default: ready_mask = ~($urandom & $urandom & $urandom);
                endcase
            end
            m_ready <= ready_mask[slot];
            slot = (slot + 1) % 32;
        end
    end

    // One command transfer. The sender runs in bursts; between bursts valid
    // drops for a random gap. Some bursts are long, giving stretches with no
    // idling on the input side. Returns at the edge that accepted the item.
    task automatic send_cmd(input logic [2:0] cmd, input logic [63:0] val);
        in_t item;
        int  gap;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            if ($urandom_range(0, 3) == 0)
                burst_left = $urandom_range(40, 120);
            else
                burst_left = $urandom_range(1, 16);
            @(negedge aclk);
            s_valid <= 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
        burst_left--;
        item.command = cmd;
        item.value   = val;
        @(negedge aclk);
        s_valid <= 1'b1;
        s_data  <= item;
        do @(posedge aclk); while (!s_ready);
        sent_items++;
        if (cmd == CMD_TICK)
            tick_items++;
    endtask

    // Stop sending and wait for every outstanding result to come back.
    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (pending != 0) @(negedge aclk);
        drains++;
    endtask

    // pulse_width is only written with the timer idle.
    task automatic write_pulse_width(input logic [31:0] width);
        wait_drained();
        repeat (SETTLE_CYCLES) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= width;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        width_writes++;
    endtask

    // Mostly ticks, with set/queue commands using small counter values so
    // that seconds keep turning over. Upper value bits are random even where
    // the timer ignores them. A few tick loads land far past the matches.
    task automatic send_random_cmd();
        int          pick;
        logic [2:0]  cmd;
        logic [63:0] val;
        pick = $urandom_range(0, 99);
        val  = {$urandom, $urandom};
        if (pick < 73) begin
            cmd = CMD_TICK;
        end else if (pick < 77) begin
            cmd = CMD_DIVISOR_NEXT;
            val[31:0] = $urandom_range(0, 40);
        end else if (pick < 80) begin
            cmd = CMD_DIVISOR_ONCE;
            val[31:0] = $urandom_range(0, 40);
        end else if (pick < 84) begin
            cmd = CMD_DELAY_NEXT;
            val[31:0] = $urandom_range(0, 40);
        end else if (pick < 87) begin
            cmd = CMD_SECONDS_NOW;
            // near the top so the seconds count wraps now and then
            if ($urandom_range(0, 3) == 0)
                val = 64'hFFFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 2));
        end else if (pick < 91) begin
            cmd = CMD_SECONDS_NEXT;
            if ($urandom_range(0, 3) == 0)
                val = '0;  // cancels a queued value
        end else if (pick < 98) begin
            cmd = CMD_TICKS_NOW;
            case ($urandom_range(0, 7))
                0:       ;  // anywhere: count runs on to the wrap
                1:       val[31:0] = 32'hFFFF_FFFF - $urandom_range(0, 3);
                default: val[31:0] = $urandom_range(0, 40);
            endcase
        end else begin
            cmd = CMD_UNUSED;
        end
        send_cmd(cmd, val);
    endtask

    initial begin : stimulus
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        burst_left = 0;
        sent_items = 0;
        tick_items = 0;
        width_writes = 0;
        drains     = 0;
        cycles     = 0;
        repeat (10) @(negedge aclk);
        aresetn <= 1'b1;

        // Directed part, narrowest pulse. Queue a divisor, a one-shot
        // divisor and a delay, then jump to the end of the power-on period.
        write_pulse_width(32'd1);
        send_cmd(CMD_TICK, '0);
        send_cmd(CMD_DIVISOR_NEXT, 64'hFFFF_FFFF_0000_0009);
        send_cmd(CMD_DIVISOR_ONCE, 64'h0000_0000_0000_0005);
        send_cmd(CMD_DELAY_NEXT, 64'h0000_0000_0000_0003);
        // queued seconds then cancelled by a zero
        send_cmd(CMD_SECONDS_NEXT, 64'h0123_4567_89AB_CDEF);
        send_cmd(CMD_SECONDS_NEXT, '0);
        // all ones: the next second start wraps the count to zero
        send_cmd(CMD_SECONDS_NOW, 64'hFFFF_FFFF_FFFF_FFFF);
        send_cmd(CMD_UNUSED, 64'h5555_5555_5555_5555);
        send_cmd(CMD_TICKS_NOW, {32'hAAAA_AAAA, INIT_DIVISOR[31:0] - 32'd1});
        send_cmd(CMD_TICK, '0);
        send_cmd(CMD_TICK, '0);                            // second start
        send_cmd(CMD_SECONDS_NEXT, 64'h8000_0000_0000_0000);
        send_cmd(CMD_TICK, '0);                            // pulse end, one-shot period
        repeat (5) send_cmd(CMD_TICK, '0);                 // trigger rises, next second
        send_cmd(CMD_TICK, '0);                            // pulse end, queued divisor
        // count loaded past every match: it must run to the wrap
        send_cmd(CMD_TICKS_NOW, 64'h0000_0000_FFFF_FFFF);
        send_cmd(CMD_TICK, '0);

        // Widest pulse: it can only end when the count reaches all ones.
        write_pulse_width(32'hFFFF_FFFF);
        send_cmd(CMD_SECONDS_NOW, 64'h7FFF_FFFF_FFFF_FFFF);
        send_cmd(CMD_TICKS_NOW, 64'd8);
        repeat (3) send_cmd(CMD_TICK, '0);
        send_cmd(CMD_TICKS_NOW, 64'h0000_0000_FFFF_FFFD);
        repeat (4) send_cmd(CMD_TICK, '0);

        // Random phases, each under its own pulse width. The last phase
        // uses wide pulses so the delay often falls inside the pulse and
        // the trigger stays low for the period.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == RANDOM_PHASES - 1)
                write_pulse_width($urandom_range(20, 60));
            else
                write_pulse_width($urandom_range(1, 12));
            repeat (ITEMS_PER_PHASE) begin
                if ($urandom_range(0, 119) == 0)
                    wait_drained();
                send_random_cmd();
            end
        end

        wait_drained();
        repeat (END_CYCLES) @(negedge aclk);

        $display("Sent %0d commands (%0d ticks), saw %0d second starts, %0d pulse widths.",
                 sent_items, tick_items, starts_seen, width_writes);
        $display("Input side paused for a full drain %0d times.", drains);
        if (fail_count == 0 && pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/pptt_pkg.sv
rtl/core/pptt_timer_core.sv
rtl/core/pps_pulse_and_trigger_timer_top.sv
tb/pps_timer_checker.sv
tb/testbench.sv
